// File: rtl/srs_pkg.sv
// Shared types and constants for the stripe request splitter.
// Used by srs_alu and stripe_request_splitter_core; depends on nothing else.
package srs_pkg;

    localparam int OFF_W    = 48;             // logical offset, device offset, host address
    localparam int CNT_W    = 18;             // request byte count
    localparam int UNIT_W   = 21;             // stripe unit and piece length
    localparam int NDEV_W   = 4;              // device count register
    localparam int IDX_W    = 3;              // device index field
    localparam int DSOR_W   = UNIT_W + NDEV_W; // stripe unit times device count
    localparam int STEP_W   = $clog2(OFF_W);  // sequencer step counter
    localparam int CFG_IDX_W = 1;

    localparam int MAX_DEVICES_DEF = 8;
    localparam int MAX_PIECES_DEF  = 64;

    localparam logic [UNIT_W-1:0] UNIT_MIN  = UNIT_W'(4096);
    localparam logic [UNIT_W-1:0] UNIT_MAX  = UNIT_W'(1048576);
    localparam logic [CNT_W-1:0]  COUNT_MAX = CNT_W'(258048);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_STRIPE_UNIT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_COUNT = 1'b1;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        t_alu_op           op;
        logic [OFF_W-1:0]  a;
        logic [OFF_W-1:0]  b;
    } t_alu_req;

    typedef struct packed {
        logic              carry;   // on a subtract: a >= b
        logic [OFF_W-1:0]  sum;
    } t_alu_res;

endpackage

// File: rtl/srs_alu.sv
// Shared 48-bit add/subtract unit of the stripe request splitter.
// Depends on srs_pkg for the request and result types.
module srs_alu (
    input  srs_pkg::t_alu_req i_req,
    output srs_pkg::t_alu_res o_res
);

    logic [srs_pkg::OFF_W-1:0] w_b;
    logic                      w_cin;
    logic [srs_pkg::OFF_W:0]   w_full;

    // Subtraction is an add of the inverted operand with a carry in, so the
    // carry out tells whether a is at least b.
    always_comb begin
        w_b    = (i_req.op == srs_pkg::ALU_SUB) ? ~i_req.b : i_req.b;
        w_cin  = (i_req.op == srs_pkg::ALU_SUB);
        w_full = {1'b0, i_req.a} + {1'b0, w_b} + {{srs_pkg::OFF_W{1'b0}}, w_cin};
    end

    assign o_res.carry = w_full[srs_pkg::OFF_W];
    assign o_res.sum   = w_full[srs_pkg::OFF_W-1:0];

endmodule

// File: rtl/stripe_request_splitter_core.sv
// Top level of the stripe request splitter: RAID-0 address mapping of a request.
// Depends on srs_pkg and instantiates the shared add/subtract unit srs_alu.
//
//   Channel   Direction  Handshake              Word
//   -------   ---------  ---------------------  -------------------------------------
//   request   in         i_valid / o_stall      action, offset, byte count, host addr
//   piece     out        o_valid / i_stall      device, device offset, length, host
//   config    in         i_cfg_wr_en            register index and write data
//
// A request runs the offset divide, the device digit step, the row multiply
// and the step that forms the device offset, then gives one piece per cycle
// while the output is free. If the logical offset wraps past 2^48 inside a
// request, the divide, digit and multiply steps run once more from there.
// A zero-byte request is taken while the sequencer is idle and gives no piece.
// The reset is synchronous and active low; it restores the default config.
// A stall on the piece side holds the sequencer in its emit state; the
// request side is stalled whenever the sequencer is not idle.
module stripe_request_splitter_core #(
    parameter int MAX_DEVICES = srs_pkg::MAX_DEVICES_DEF,
    parameter int MAX_PIECES  = srs_pkg::MAX_PIECES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_action,
    input  logic [srs_pkg::OFF_W-1:0]      i_logical_offset,
    input  logic [srs_pkg::CNT_W-1:0]      i_byte_count,
    input  logic [srs_pkg::OFF_W-1:0]      i_host_address,

    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_piece_action,
    output logic [srs_pkg::IDX_W-1:0]      o_device_index,
    output logic [srs_pkg::OFF_W-1:0]      o_device_offset,
    output logic [srs_pkg::UNIT_W-1:0]     o_piece_bytes,
    output logic [srs_pkg::OFF_W-1:0]      o_piece_host_address,
    output logic                           o_last_piece,

    input  logic                           i_cfg_wr_en,
    input  logic [srs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [srs_pkg::UNIT_W-1:0]     i_cfg_wr_data
);

    localparam int OFF_W  = srs_pkg::OFF_W;
    localparam int CNT_W  = srs_pkg::CNT_W;
    localparam int UNIT_W = srs_pkg::UNIT_W;
    localparam int NDEV_W = srs_pkg::NDEV_W;
    localparam int IDX_W  = srs_pkg::IDX_W;
    localparam int DSOR_W = srs_pkg::DSOR_W;
    localparam int STEP_W = srs_pkg::STEP_W;
    localparam int UIDX_W = $clog2(UNIT_W);

    // The device count register holds at most 15, so that caps the device range too.
    localparam int NDEV_MAX_REG = (1 << NDEV_W) - 1;
    localparam int NDEV_CAP = (MAX_DEVICES < NDEV_MAX_REG) ? MAX_DEVICES : NDEV_MAX_REG;
    localparam int DEV_W    = (NDEV_CAP > 1) ? $clog2(NDEV_CAP) : 1;
    localparam int K_W      = $clog2(MAX_PIECES);

    localparam logic [NDEV_W-1:0] NDEV_ONE   = NDEV_W'(1);
    localparam logic [NDEV_W-1:0] NDEV_LIMIT = NDEV_W'(NDEV_CAP);
    localparam logic [K_W-1:0]    K_LAST     = K_W'(MAX_PIECES - 1);
    localparam logic [STEP_W-1:0] DIV_START  = STEP_W'(OFF_W - 1);
    localparam logic [STEP_W-1:0] DEV_START  = STEP_W'(DEV_W - 1);
    localparam logic [STEP_W-1:0] MUL_START  = STEP_W'(UNIT_W - 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIV  = 6'b000010,
        S_DEV  = 6'b000100,
        S_MUL  = 6'b001000,
        S_DOFF = 6'b010000,
        S_EMIT = 6'b100000
    } t_state;

    t_state                 r_state;
    t_state                 n_state;
    logic [STEP_W-1:0]      r_cnt;

    // Effective configuration, already saturated into its legal range.
    logic [UNIT_W-1:0]      r_unit;
    logic [NDEV_W-1:0]      r_ndev;

    // Request context.
    logic                   r_act;
    logic [OFF_W-1:0]       r_off;
    logic [CNT_W-1:0]       r_left;
    logic [OFF_W-1:0]       r_host;
    logic [K_W-1:0]         r_k;
    logic [DSOR_W-1:0]      r_dsor;

    // Sequencer working registers.
    logic [OFF_W-1:0]       r_quo;
    logic [DSOR_W-1:0]      r_rem;
    logic [DEV_W-1:0]       r_d;
    logic [OFF_W-1:0]       r_base;
    logic [OFF_W-1:0]       r_doff;
    logic [UNIT_W-1:0]      r_within;

    // Output word register.
    logic                   r_ovalid;
    logic                   r_o_act;
    logic [IDX_W-1:0]       r_o_idx;
    logic [OFF_W-1:0]       r_o_doff;
    logic [UNIT_W-1:0]      r_o_len;
    logic [OFF_W-1:0]       r_o_host;
    logic                   r_o_last;

    srs_pkg::t_alu_req      w_alu_req;
    srs_pkg::t_alu_res      w_alu_res;

    logic                   w_in_acc;
    logic                   w_emit;
    logic                   w_last;
    logic                   w_dev_wrap;
    logic [CNT_W-1:0]       w_left_in;
    logic [UNIT_W-1:0]      w_room;
    logic [UNIT_W-1:0]      w_len;
    logic [DSOR_W-1:0]      w_shift;
    logic [DSOR_W-1:0]      w_rem_op;
    logic [DSOR_W-1:0]      w_rem_next;
    logic [OFF_W-1:0]       w_base_next;
    logic [UNIT_W-1:0]      w_cfg_unit;
    logic [NDEV_W-1:0]      w_cfg_ndev;

    srs_alu u_alu (
        .i_req (w_alu_req),
        .o_res (w_alu_res)
    );

    assign o_stall  = (r_state != S_IDLE);
    assign w_in_acc = i_valid && (r_state == S_IDLE);
    assign w_emit   = (r_state == S_EMIT) && (!r_ovalid || !i_stall);

    // Saturate the incoming values of the configuration registers.
    always_comb begin
        if (i_cfg_wr_data < srs_pkg::UNIT_MIN) begin
            w_cfg_unit = srs_pkg::UNIT_MIN;
        end else if (i_cfg_wr_data > srs_pkg::UNIT_MAX) begin
            w_cfg_unit = srs_pkg::UNIT_MAX;
        end else begin
            w_cfg_unit = i_cfg_wr_data;
        end
        if (i_cfg_wr_data[NDEV_W-1:0] == '0) begin
            w_cfg_ndev = NDEV_ONE;
        end else if (i_cfg_wr_data[NDEV_W-1:0] > NDEV_LIMIT) begin
            w_cfg_ndev = NDEV_LIMIT;
        end else begin
            w_cfg_ndev = i_cfg_wr_data[NDEV_W-1:0];
        end
    end

    assign w_left_in = (i_byte_count > srs_pkg::COUNT_MAX) ? srs_pkg::COUNT_MAX : i_byte_count;

    // A piece runs to the end of the current stripe unit or to the end of the
    // request, whichever comes first.
    assign w_room = r_unit - r_within;
    assign w_len  = (UNIT_W'(r_left) < w_room) ? UNIT_W'(r_left) : w_room;
    assign w_last = (UNIT_W'(r_left) == w_len) || (r_k == K_LAST);

    // Stepping past the last device starts the next stripe row.
    assign w_dev_wrap  = ((NDEV_W'(r_d) + NDEV_ONE) == r_ndev);
    assign w_base_next = r_base + OFF_W'(r_unit);

    // Restoring division: the divide step brings in the next dividend bit,
    // the device digit step works on the remainder in place.
    assign w_shift    = {r_rem[DSOR_W-2:0], r_quo[OFF_W-1]};
    assign w_rem_op   = (r_state == S_DIV) ? w_shift : r_rem;
    assign w_rem_next = w_alu_res.carry ? w_alu_res.sum[DSOR_W-1:0] : w_rem_op;

    // Operand selection for the shared add/subtract unit.
    always_comb begin
        w_alu_req.op = srs_pkg::ALU_ADD;
        w_alu_req.a  = '0;
        w_alu_req.b  = '0;
        unique case (r_state)
            S_IDLE: begin
            end
            S_DIV: begin
                // Offset divided by one whole stripe row (unit times devices).
                w_alu_req.op = srs_pkg::ALU_SUB;
                w_alu_req.a  = OFF_W'(w_shift);
                w_alu_req.b  = OFF_W'(r_dsor);
            end
            S_DEV: begin
                // The row remainder divided by the unit gives device and offset in unit.
                w_alu_req.op = srs_pkg::ALU_SUB;
                w_alu_req.a  = OFF_W'(r_rem);
                w_alu_req.b  = OFF_W'(r_unit) << r_cnt;
            end
            S_MUL: begin
                // Shift-and-add row times unit, from the top bit of the unit down.
                w_alu_req.a = r_base << 1;
                w_alu_req.b = r_unit[r_cnt[UIDX_W-1:0]] ? r_quo : '0;
            end
            S_DOFF: begin
                w_alu_req.a = r_base;
                w_alu_req.b = OFF_W'(r_within);
            end
            S_EMIT: begin
                // Advance the logical offset; the carry flags a wrap past 2^48.
                w_alu_req.a = r_off;
                w_alu_req.b = OFF_W'(w_len);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && (i_byte_count != '0)) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_cnt == '0) begin
                    n_state = S_DEV;
                end
            end
            S_DEV: begin
                if (r_cnt == '0) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (r_cnt == '0) begin
                    n_state = S_DOFF;
                end
            end
            S_DOFF: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_emit) begin
                    if (w_last) begin
                        n_state = S_IDLE;
                    end else if (w_alu_res.carry) begin
                        n_state = S_DIV;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_unit   <= srs_pkg::UNIT_MIN;
            r_ndev   <= NDEV_ONE;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    srs_pkg::CFG_STRIPE_UNIT:  r_unit <= w_cfg_unit;
                    srs_pkg::CFG_DEVICE_COUNT: r_ndev <= w_cfg_ndev;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Datapath of the sequencer and the output word.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    r_act  <= i_action;
                    r_off  <= i_logical_offset;
                    r_left <= w_left_in;
                    r_host <= i_host_address;
                    r_k    <= '0;
                    r_dsor <= DSOR_W'(r_unit) * DSOR_W'(r_ndev);
                    r_quo  <= i_logical_offset;
                    r_rem  <= '0;
                    r_cnt  <= DIV_START;
                end
            end
            S_DIV: begin
                r_quo <= {r_quo[OFF_W-2:0], w_alu_res.carry};
                r_rem <= w_rem_next;
                if (r_cnt == '0) begin
                    r_cnt <= DEV_START;
                    r_d   <= '0;
                end else begin
                    r_cnt <= r_cnt - STEP_W'(1);
                end
            end
            S_DEV: begin
                r_rem <= w_rem_next;
                r_d   <= (r_d << 1) | DEV_W'(w_alu_res.carry);
                if (r_cnt == '0) begin
                    r_cnt    <= MUL_START;
                    r_base   <= '0;
                    r_within <= w_rem_next[UNIT_W-1:0];
                end else begin
                    r_cnt <= r_cnt - STEP_W'(1);
                end
            end
            S_MUL: begin
                r_base <= w_alu_res.sum;
                r_cnt  <= r_cnt - STEP_W'(1);
            end
            S_DOFF: begin
                r_doff <= w_alu_res.sum;
            end
            S_EMIT: begin
                if (w_emit) begin
                    r_o_act  <= r_act;
                    r_o_idx  <= IDX_W'(r_d);
                    r_o_doff <= r_doff;
                    r_o_len  <= w_len;
                    r_o_host <= r_host;
                    r_o_last <= w_last;

                    r_off  <= w_alu_res.sum;
                    r_host <= r_host + OFF_W'(w_len);
                    r_left <= r_left - CNT_W'(w_len);
                    r_k    <= r_k + K_W'(1);

                    if (!w_last) begin
                        if (w_alu_res.carry) begin
                            // The offset wrapped, so map the new offset from scratch.
                            r_quo <= w_alu_res.sum;
                            r_rem <= '0;
                            r_cnt <= DIV_START;
                        end else begin
                            // The next piece starts a fresh unit on the next device.
                            r_within <= '0;
                            if (w_dev_wrap) begin
                                r_d    <= '0;
                                r_base <= w_base_next;
                                r_doff <= w_base_next;
                            end else begin
                                r_d    <= r_d + DEV_W'(1);
                                r_doff <= r_base;
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid              = r_ovalid;
    assign o_piece_action       = r_o_act;
    assign o_device_index       = r_o_idx;
    assign o_device_offset      = r_o_doff;
    assign o_piece_bytes        = r_o_len;
    assign o_piece_host_address = r_o_host;
    assign o_last_piece         = r_o_last;

    // The divide runs its full count before the device digit step begins.
    a_div_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt != '0) |=> (r_state == S_DIV))
        else $error("divide sequence left early");

    // A request with bytes to move always starts the divide.
    a_req_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_byte_count != '0) |=> (r_state == S_DIV))
        else $error("nonempty request did not start the divide");

    // Pieces are only cut while bytes remain.
    a_emit_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_left != '0))
        else $error("emit state with no bytes left");

    // No piece of zero length is ever shown.
    a_piece_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_piece_bytes != '0))
        else $error("zero-length piece on the output");

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for the stripe request splitter (RAID-0 address mapping).
// Depends on srs_pkg and stripe_request_splitter_core; a scoreboard class predicts each piece.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OFF_W           = srs_pkg::OFF_W;
    localparam int CNT_W           = srs_pkg::CNT_W;
    localparam int UNIT_W          = srs_pkg::UNIT_W;
    localparam int NDEV_W          = srs_pkg::NDEV_W;
    localparam int IDX_W           = srs_pkg::IDX_W;
    localparam int CFG_IDX_W       = srs_pkg::CFG_IDX_W;
    localparam int MAX_DEVICES_DEF = srs_pkg::MAX_DEVICES_DEF;
    localparam int MAX_PIECES_DEF  = srs_pkg::MAX_PIECES_DEF;
    localparam logic [UNIT_W-1:0] UNIT_MIN  = srs_pkg::UNIT_MIN;
    localparam logic [UNIT_W-1:0] UNIT_MAX  = srs_pkg::UNIT_MAX;
    localparam logic [CNT_W-1:0]  COUNT_MAX = srs_pkg::COUNT_MAX;

    // Cycles to wait with nothing expected before the block counts as idle.
    // This covers a request that wraps past 2^48 and reruns its divide.
    localparam int SETTLE_CYCLES = 256;
    // Cycles with no word accepted anywhere before the run is called hung.
    localparam int IDLE_LIMIT = 4000;
    localparam int RANDOM_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 55;

    // One piece word as it leaves the block.
    typedef struct packed {
        logic              action;
        logic [IDX_W-1:0]  device_index;
        logic [OFF_W-1:0]  device_offset;
        logic [UNIT_W-1:0] piece_bytes;
        logic [OFF_W-1:0]  host_address;
        logic              last_piece;
    } t_stripe_piece;

    // Keeps its own copy of the two registers, splits each accepted request
    // into the pieces it must give and checks pieces in order.
    class piece_scoreboard;
        localparam longint unsigned ADDR_MASK = 64'h0000_FFFF_FFFF_FFFF;

        t_stripe_piece     pending_pieces[$];
        logic [UNIT_W-1:0] unit_reg;
        logic [NDEV_W-1:0] count_reg;
        int                mismatches;

        function new();
            unit_reg   = UNIT_MIN;
            count_reg  = NDEV_W'(1);
            mismatches = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] index, logic [UNIT_W-1:0] data);
            if (index == srs_pkg::CFG_STRIPE_UNIT) begin
                unit_reg = data;
            end else begin
                count_reg = data[NDEV_W-1:0];
            end
        endfunction

        function int outstanding();
            return pending_pieces.size();
        endfunction

        task report(string what);
            $display("ERROR at %0t ns: %s", $time, what);
            mismatches++;
        endtask

        // Walks the request one stripe unit at a time. Out-of-range register
        // values and byte counts are clamped the way the block clamps them.
        function void note_request(logic act, logic [OFF_W-1:0] offset_in,
                                   logic [CNT_W-1:0] count_in, logic [OFF_W-1:0] host_in);
            longint unsigned unit;
            longint unsigned ndev;
            longint unsigned left;
            longint unsigned off;
            longint unsigned host;
            longint unsigned in_unit;
            longint unsigned len;
            int              k;
            t_stripe_piece   p;
            unit = unit_reg;
            if (unit < UNIT_MIN) unit = UNIT_MIN;
            if (unit > UNIT_MAX) unit = UNIT_MAX;
            ndev = count_reg;
            if (ndev < 1) ndev = 1;
            if (ndev > MAX_DEVICES_DEF) ndev = MAX_DEVICES_DEF;
            left = count_in;
            if (left > COUNT_MAX) left = COUNT_MAX;
            off  = offset_in;
            host = host_in;
            k    = 0;
            while (left > 0 && k < MAX_PIECES_DEF) begin
                in_unit = off % unit;
                len     = unit - in_unit;
                if (len > left) len = left;
                p.action        = act;
                p.device_index  = IDX_W'((off / unit) % ndev);
                p.device_offset = OFF_W'((off / (unit * ndev)) * unit + in_unit);
                p.piece_bytes   = UNIT_W'(len);
                p.host_address  = OFF_W'(host);
                p.last_piece    = 1'b0;
                pending_pieces.insert(pending_pieces.size(), p);
                off  = (off + len) & ADDR_MASK;
                host = (host + len) & ADDR_MASK;
                left = left - len;
                k++;
            end
            if (k > 0) pending_pieces[pending_pieces.size() - 1].last_piece = 1'b1;
        endfunction

        task check_piece(t_stripe_piece got);
            t_stripe_piece want;
            if (pending_pieces.size() == 0) begin
                report($sformatf("piece with nothing expected: dev %0d off %h len %0d",
                                 got.device_index, got.device_offset, got.piece_bytes));
                return;
            end
            want = pending_pieces[0];
            pending_pieces.delete(0);
            if (got.action !== want.action || got.device_index !== want.device_index ||
                got.device_offset !== want.device_offset ||
                got.piece_bytes !== want.piece_bytes ||
                got.host_address !== want.host_address ||
                got.last_piece !== want.last_piece) begin
                report($sformatf({"piece got act %b dev %0d off %h len %0d host %h last %b,",
                                  " want act %b dev %0d off %h len %0d host %h last %b"},
                                 got.action, got.device_index, got.device_offset,
                                 got.piece_bytes, got.host_address, got.last_piece,
                                 want.action, want.device_index, want.device_offset,
                                 want.piece_bytes, want.host_address, want.last_piece));
            end
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic               i_action;
    logic [OFF_W-1:0]   i_logical_offset;
    logic [CNT_W-1:0]   i_byte_count;
    logic [OFF_W-1:0]   i_host_address;
    logic               o_valid;
    logic               i_stall;
    logic               o_piece_action;
    logic [IDX_W-1:0]   o_device_index;
    logic [OFF_W-1:0]   o_device_offset;
    logic [UNIT_W-1:0]  o_piece_bytes;
    logic [OFF_W-1:0]   o_piece_host_address;
    logic               o_last_piece;
    logic               i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [UNIT_W-1:0]  i_cfg_wr_data;

    piece_scoreboard    sb = new();
    bit                 idling = 1'b1;   // random gaps and stalls allowed
    int                 stall_left = 0;
    int                 quiet_cycles = 0;

    stripe_request_splitter_core u_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_action             (i_action),
        .i_logical_offset     (i_logical_offset),
        .i_byte_count         (i_byte_count),
        .i_host_address       (i_host_address),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_piece_action       (o_piece_action),
        .o_device_index       (o_device_index),
        .o_device_offset      (o_device_offset),
        .o_piece_bytes        (o_piece_bytes),
        .o_piece_host_address (o_piece_host_address),
        .o_last_piece         (o_last_piece),
        .i_cfg_wr_en          (i_cfg_wr_en),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_wr_data        (i_cfg_wr_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The piece side stalls in bursts of random length while idling is on.
    always @(negedge i_clk) begin
        if (stall_left == 0 && idling && i_rst_n && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 10);
        end
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Piece words are checked at the edge that takes them. The watchdog
    // restarts whenever any word or register write goes through.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_piece({o_piece_action, o_device_index, o_device_offset,
                            o_piece_bytes, o_piece_host_address, o_last_piece});
        end
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_wr_en || !i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [OFF_W-1:0] rand48();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[OFF_W-1:0];
    endfunction

    // Presents one request word, holds it until taken, then maybe leaves a gap.
    task send_request(logic act, logic [OFF_W-1:0] off, logic [CNT_W-1:0] cnt,
                      logic [OFF_W-1:0] host);
        int gap;
        @(negedge i_clk);
        i_valid          <= 1'b1;
        i_action         <= act;
        i_logical_offset <= off;
        i_byte_count     <= cnt;
        i_host_address   <= host;
        do @(posedge i_clk); while (o_stall);
        sb.note_request(act, off, cnt, host);
        if (idling && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 10);
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Stops sending and waits until every expected piece has come, plus
    // enough cycles for a trailing zero-byte request to finish.
    task settle_block();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task write_register(logic [CFG_IDX_W-1:0] index, logic [UNIT_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_index   <= index;
        i_cfg_wr_data <= data;
        sb.set_register(index, data);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    task configure(logic [UNIT_W-1:0] unit, logic [UNIT_W-1:0] ndev);
        settle_block();
        write_register(srs_pkg::CFG_STRIPE_UNIT, unit);
        write_register(srs_pkg::CFG_DEVICE_COUNT, ndev);
    endtask

    // Random request: mostly ordinary sizes, with zero, oversized, unit-edge
    // and near-wrap offsets mixed in.
    task random_request();
        int                sel;
        logic [CNT_W-1:0]  cnt;
        logic [OFF_W-1:0]  off;
        logic [OFF_W-1:0]  host;
        sel = $urandom_range(0, 99);
        if (sel < 8)       cnt = '0;
        else if (sel < 20) cnt = CNT_W'($urandom_range(1, 64));
        else if (sel < 55) cnt = CNT_W'($urandom_range(1, 16384));
        else if (sel < 85) cnt = CNT_W'($urandom_range(1, COUNT_MAX));
        else if (sel < 95) cnt = CNT_W'($urandom_range(0, 2**CNT_W - 1));
        else               cnt = COUNT_MAX;
        sel = $urandom_range(0, 99);
        off = rand48();
        if (sel >= 60 && sel < 75) begin
            off = {OFF_W{1'b1}} - OFF_W'($urandom_range(0, 300000));
        end else if (sel >= 75) begin
            off[11:0] = $urandom_range(0, 1) ? 12'($urandom_range(0, 3))
                                              : 12'(4095 - $urandom_range(0, 3));
        end
        host = rand48();
        if ($urandom_range(0, 99) < 15) host = {OFF_W{1'b1}} - OFF_W'($urandom_range(0, 300000));
        send_request(1'($urandom_range(0, 1)), off, cnt, host);
    endtask

    initial begin
        logic [UNIT_W-1:0] unit;
        logic [UNIT_W-1:0] ndev;
        int                sel;
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_action         = 1'b0;
        i_logical_offset = '0;
        i_byte_count     = '0;
        i_host_address   = '0;
        i_stall          = 1'b0;
        i_cfg_wr_en      = 1'b0;
        i_cfg_index      = srs_pkg::CFG_STRIPE_UNIT;
        i_cfg_wr_data    = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Smallest unit, one device: zero bytes, single byte, host wrap,
        // full and misaligned maximum counts, oversized count, offset wrap.
        configure(UNIT_MIN, 1);
        send_request(1'b0, '0, '0, '0);
        send_request(1'b1, '0, 1, '0);
        send_request(1'b0, 48'd4095, 2, {OFF_W{1'b1}});
        send_request(1'b1, '0, COUNT_MAX, 48'h1000);
        send_request(1'b0, 48'd1, COUNT_MAX, 48'h0000_1234_5678);
        send_request(1'b1, 48'h123, {CNT_W{1'b1}}, 48'h7FFF_FFFF_FFFF);
        send_request(1'b0, {OFF_W{1'b1}}, 4096, 48'h10);

        // Largest unit over the most devices.
        configure(UNIT_MAX, UNIT_W'(MAX_DEVICES_DEF));
        send_request(1'b1, {OFF_W{1'b1}} - 48'd100, 1000, {OFF_W{1'b1}});
        send_request(1'b0, 48'd1048575, 2, 48'h55);
        send_request(1'b1, 48'd7340037, COUNT_MAX, 48'hABCDE);
        send_request(1'b0, 48'd8388608, 1, 48'h0);
        send_request(1'b1, rand48(), '0, rand48());

        // Register values below range are clamped to the minimum unit and one device.
        configure('0, '0);
        send_request(1'b0, 48'd8191, 4097, 48'h0);
        send_request(1'b1, 48'h5555_5555_5555, 18'h2AAAA, 48'hAAAA_AAAA_AAAA);

        // Register values above range are clamped to the maximum unit and device limit.
        configure({UNIT_W{1'b1}}, 15);
        send_request(1'b0, 48'hAAAA_AAAA_AAAA, 18'h15555, 48'h5555_5555_5555);
        send_request(1'b1, 48'hFFFF_FFF0_0000, COUNT_MAX, 48'h0);

        // A unit that is not a power of two, over three devices.
        configure(12288, 3);
        send_request(1'b0, 48'd12287, 24578, 48'h0);
        send_request(1'b1, {OFF_W{1'b1}}, 3, 48'hFFFF_FFFF_FFFE);
        send_request(1'b0, 48'h8000_0000_0000, 100000, 48'h1);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            sel = $urandom_range(0, 5);
            case (sel)
                0: unit = UNIT_MIN;
                1: unit = UNIT_W'(4096 << $urandom_range(1, 4));
                2: unit = UNIT_MAX;
                3: unit = UNIT_W'($urandom_range(UNIT_MIN, UNIT_MAX));
                4: unit = UNIT_W'($urandom_range(0, 2**UNIT_W - 1));
                default: unit = UNIT_W'($urandom_range(0, 4095));
            endcase
            if ($urandom_range(0, 3) == 0) ndev = UNIT_W'($urandom_range(0, 15));
            else ndev = UNIT_W'($urandom_range(1, MAX_DEVICES_DEF));
            configure(unit, ndev);
            // The last phase runs with neither side idling.
            idling = (ph != RANDOM_PHASES - 1);
            repeat (ITEMS_PER_PHASE) random_request();
        end

        settle_block();
        if (sb.outstanding() != 0) begin
            sb.report($sformatf("%0d expected pieces never arrived", sb.outstanding()));
        end
        if (sb.mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
